/* hw/rtl/dtt_pkg.sv */
package dtt_pkg;

  localparam int NumStates  = 8;
  localparam int NumSymbols = 8;

  localparam int StateW = 3;
  localparam int SymW   = 3;
  localparam int ThrW   = 16;
  localparam int RunW   = 17;
  localparam int CountW = 32;

  // range limits one bit wider than the fields they guard
  localparam logic [StateW:0] StateLimit = (StateW + 1)'(NumStates);
  localparam logic [SymW:0]   SymLimit   = (SymW + 1)'(NumSymbols);

  localparam logic [RunW-1:0]   RunMax   = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    OpFeed  = 2'd0,
    OpWrite = 2'd1,
    OpClear = 2'd2,
    OpNone  = 2'd3
  } op_e;

  // one table entry: threshold and next state for a (state, symbol) pair
  typedef struct packed {
    logic [ThrW-1:0]   thr;
    logic [StateW-1:0] nxt;
  } entry_t;

  // one memory word: the entries of every state for one symbol
  typedef entry_t [NumStates-1:0] row_t;

  typedef struct packed {
    logic [StateW-1:0] present;
    logic [SymW-1:0]   last_sym;
    logic [RunW-1:0]   run;
    logic [CountW-1:0] dwell;
    logic [CountW-1:0] prior;
  } fsm_t;

endpackage

/* hw/rtl/dwell_threshold_table_fsm_unit.sv */
// pipeline: the memory read is registered at the item transfer, then the state
//   update is registered into the output register when stage one advances
// throughput: one item per cycle while results drain; the table is read by symbol so
//   the row is fetched before the present state is known, and the state lane is picked late
// reset: control state, present state and all counters clear at once; the table holds
//   no reset value, and the user must only read entries written before (not enforced)
module dwell_threshold_table_fsm_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [2:0]  symbol_i,
  input  logic [2:0]  table_state_i,
  input  logic [15:0] threshold_value_i,
  input  logic [2:0]  next_state_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  current_state_o,
  output logic [31:0] state_count_o,
  output logic [31:0] previous_state_count_o
);

  // handshake bookkeeping
  logic in_xfer;
  logic s1_adv;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;

  // item held during the memory read
  dtt_pkg::op_e              s1_op_q;
  logic [dtt_pkg::SymW-1:0]  s1_sym_q;

  // architectural state and output register
  dtt_pkg::fsm_t fsm_q, fsm_d;
  dtt_pkg::fsm_t res_q;

  // table access
  logic            wr_en;
  dtt_pkg::entry_t wr_data;
  dtt_pkg::row_t   rd_row;

  // stage one moves on when the output register is empty or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  // table writes land at transfer time, so a later feed item reads them
  // through the normal read path with no forwarding needed
  assign wr_en = in_xfer && (dtt_pkg::op_e'(op_i) == dtt_pkg::OpWrite)
                 && ({1'b0, symbol_i} < dtt_pkg::SymLimit)
                 && ({1'b0, table_state_i} < dtt_pkg::StateLimit)
                 && ({1'b0, next_state_value_i} < dtt_pkg::StateLimit);
  assign wr_data.thr = threshold_value_i;
  assign wr_data.nxt = next_state_value_i;

  dtt_table_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_col_i  (symbol_i),
    .wr_row_i  (table_state_i),
    .wr_data_i (wr_data),
    .rd_en_i   (in_xfer),
    .rd_col_i  (symbol_i),
    .rd_data_o (rd_row)
  );

  // run, dwell and transition update on the fetched row
  dtt_update u_upd (
    .op_i  (s1_op_q),
    .sym_i (s1_sym_q),
    .row_i (rd_row),
    .cur_i (fsm_q),
    .nxt_o (fsm_d)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_adv) s1_valid_d = 1'b0;
    if (in_xfer) s1_valid_d = 1'b1;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (s1_adv) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fsm_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) fsm_q <= fsm_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q  <= dtt_pkg::op_e'(op_i);
      s1_sym_q <= symbol_i;
    end
    if (s1_adv) res_q <= fsm_d;
  end

  assign out_valid_o            = out_valid_q;
  assign current_state_o        = res_q.present;
  assign state_count_o          = res_q.dwell;
  assign previous_state_count_o = res_q.prior;

endmodule

/* hw/rtl/dtt_table_mem.sv */
module dtt_table_mem (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [dtt_pkg::SymW-1:0]    wr_col_i,
  input  logic [dtt_pkg::StateW-1:0]  wr_row_i,
  input  dtt_pkg::entry_t             wr_data_i,
  input  logic                        rd_en_i,
  input  logic [dtt_pkg::SymW-1:0]    rd_col_i,
  output dtt_pkg::row_t               rd_data_o
);

  // word per symbol, lane per source state
  dtt_pkg::row_t mem_q [dtt_pkg::NumSymbols];
  dtt_pkg::row_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_col_i][wr_row_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_col_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* hw/rtl/dtt_update.sv */
module dtt_update (
  input  dtt_pkg::op_e              op_i,
  input  logic [dtt_pkg::SymW-1:0]  sym_i,
  input  dtt_pkg::row_t             row_i,
  input  dtt_pkg::fsm_t             cur_i,
  output dtt_pkg::fsm_t             nxt_o
);

  logic [dtt_pkg::RunW-1:0]   run_n;
  logic [dtt_pkg::CountW-1:0] dwell_n;
  dtt_pkg::entry_t            entry;

  always_comb begin
    nxt_o   = cur_i;
    run_n   = cur_i.run;
    dwell_n = cur_i.dwell;
    entry   = row_i[cur_i.present];
    case (op_i)
      dtt_pkg::OpFeed: begin
        if ({1'b0, sym_i} < dtt_pkg::SymLimit) begin
          if (sym_i == cur_i.last_sym) begin
            if (cur_i.run != dtt_pkg::RunMax) run_n = cur_i.run + 1'b1;
          end else begin
            run_n = dtt_pkg::RunW'(1);
          end
          if (cur_i.dwell != dtt_pkg::CountMax) dwell_n = cur_i.dwell + 1'b1;
          nxt_o.last_sym = sym_i;
          nxt_o.run      = run_n;
          nxt_o.dwell    = dwell_n;
          if (run_n > {1'b0, entry.thr}) begin
            // threshold exceeded: move, a real change also rolls the dwell
            if (entry.nxt != cur_i.present) begin
              nxt_o.prior = (dwell_n >= dtt_pkg::CountW'(run_n)) ?
                            dwell_n - dtt_pkg::CountW'(run_n) : '0;
              nxt_o.dwell = dtt_pkg::CountW'(run_n);
            end
            nxt_o.present = entry.nxt;
            nxt_o.run     = dtt_pkg::RunW'(1);
          end
        end
      end
      dtt_pkg::OpClear: begin
        nxt_o = '0;
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

/* hw/rtl/dtt_checker.sv */
module dtt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  op_i,
  input logic [2:0]  symbol_i,
  input logic [2:0]  table_state_i,
  input logic [15:0] threshold_value_i,
  input logic [2:0]  next_state_value_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  current_state_o,
  input logic [31:0] state_count_o,
  input logic [31:0] previous_state_count_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(current_state_o)
      && $stable(state_count_o) && $stable(previous_state_count_o))
    else $error("stalled result changed");

  // input side only stalls behind a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // zero dwell only after reset or clear, where everything is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (state_count_o == 32'd0) |->
      (previous_state_count_o == 32'd0) && (current_state_o == 3'd0))
    else $error("zero dwell with nonzero state");

endmodule

bind dwell_threshold_table_fsm_unit dtt_checker u_dtt_checker (.*);
